@@ hdl/cisub_pkg.sv @@
// Package with the opcode codes, flag bit positions and widths of the instruction step block.
`timescale 1ns / 1ps

package cisub_pkg;

	// Primary opcodes that the block executes.
	localparam logic [7:0] OP_LD_BC_D16 = 8'h01;
	localparam logic [7:0] OP_LD_IBC_A  = 8'h02;
	localparam logic [7:0] OP_INC_BC    = 8'h03;
	localparam logic [7:0] OP_INC_B     = 8'h04;
	localparam logic [7:0] OP_INC_C     = 8'h0C;
	localparam logic [7:0] OP_LD_C_D8   = 8'h0E;
	localparam logic [7:0] OP_JR_NZ     = 8'h20;
	localparam logic [7:0] OP_LD_HL_D16 = 8'h21;
	localparam logic [7:0] OP_LD_SP_D16 = 8'h31;
	localparam logic [7:0] OP_LDD_IHL_A = 8'h32;
	localparam logic [7:0] OP_LD_A_D8   = 8'h3E;
	localparam logic [7:0] OP_LD_IHL_A  = 8'h77;
	localparam logic [7:0] OP_XOR_A     = 8'hAF;
	localparam logic [7:0] OP_LDH_IA8_A = 8'hE0;
	localparam logic [7:0] OP_LDH_IC_A  = 8'hE2;
	localparam logic [7:0] OP_PREFIX_CB = 8'hCB;

	// Extended opcode behind the prefix.
	localparam logic [7:0] CB_BIT7_H = 8'h7C;

	// High page used by the LDH forms.
	localparam logic [7:0] HIGH_PAGE = 8'hFF;

	// Flag bit positions in F.
	localparam int FLAG_Z = 7;
	localparam int FLAG_N = 6;
	localparam int FLAG_H = 5;
	localparam int FLAG_C = 4;

	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 16;
	localparam int MCYC_W  = 3;
	localparam int TICK_W  = 5;

endpackage

@@ hdl/cisub_if.sv @@
// Valid/ready channel interfaces for the instruction and result transactions.
`timescale 1ns / 1ps

interface cisub_instr_if;
	logic       valid;
	logic       ready;
	logic [7:0] opcode_byte;
	logic [7:0] second_byte;
	logic [7:0] third_byte;

	modport source (output valid, output opcode_byte, output second_byte,
		output third_byte, input ready);
	modport sink (input valid, input opcode_byte, input second_byte,
		input third_byte, output ready);
endinterface

interface cisub_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] next_pc;
	logic        mem_write;
	logic [15:0] write_addr;
	logic [7:0]  write_data;
	logic        halted;
	logic [2:0]  machine_cycles;
	logic [4:0]  clock_cycles;
	logic [7:0]  acc_out;
	logic [7:0]  flags_out;
	logic [15:0] bc_out;
	logic [15:0] hl_out;
	logic [15:0] sp_out;

	modport source (output valid, output next_pc, output mem_write, output write_addr,
		output write_data, output halted, output machine_cycles, output clock_cycles,
		output acc_out, output flags_out, output bc_out, output hl_out, output sp_out,
		input ready);
	modport sink (input valid, input next_pc, input mem_write, input write_addr,
		input write_data, input halted, input machine_cycles, input clock_cycles,
		input acc_out, input flags_out, input bc_out, input hl_out, input sp_out,
		output ready);
endinterface

@@ hdl/cpu_instruction_step_subset.sv @@
// Top level of the instruction step block: register file, decode and result register.
`timescale 1ns / 1ps

// Each instruction transaction carries the opcode byte and the two bytes that follow
// it, and the block executes the whole instruction in the cycle it is accepted: it
// updates A, F, BC, HL, SP and PC and captures one result transaction in the output
// register. One instruction is accepted every clock cycle; the only thing that sets
// this figure is the single output register, which lets a new instruction in as long
// as the held result is being taken in the same cycle or the register is empty. The
// result gives the next PC, at most one memory byte write (the byte is always A),
// the cycle counts of the instruction and the register values after it. Any opcode
// outside the supported subset stops the CPU: from then on every instruction is
// ignored and its result repeats the current registers with halted set, no write and
// zero cycle counts. Only reset brings the CPU back to running from PC zero.
module cpu_instruction_step_subset (
	input  logic           clk,
	input  logic           arst_n,
	cisub_instr_if.sink    instr,
	cisub_result_if.source result
);
	import cisub_pkg::*;

	// Architectural state.
	logic [BYTE_W-1:0] acc_q, flags_q;
	logic [WORD_W-1:0] bc_q, hl_q, sp_q, pc_q;
	logic              stopped_q;

	// Next state and result fields for the instruction at the input.
	logic [BYTE_W-1:0] acc_n, flags_n;
	logic [WORD_W-1:0] bc_n, hl_n, sp_n, pc_n, pc_base, waddr_n;
	logic              stopped_n, wr_n;
	logic [1:0]        len_n;
	logic [TICK_W-1:0] ticks_n;
	logic [WORD_W-1:0] imm16;
	logic [WORD_W-1:0] jr_offset;

	logic res_valid_q;
	logic accept;

	// Flags of an 8-bit increment: carry is kept, half carry comes out of the low nibble.
	function automatic logic [BYTE_W-1:0] inc_flags(input logic [BYTE_W-1:0] operand,
		input logic [BYTE_W-1:0] flags);
		logic [BYTE_W-1:0] f;
		f = '0;
		f[FLAG_C] = flags[FLAG_C];
		f[FLAG_Z] = (operand == {BYTE_W{1'b1}});
		f[FLAG_H] = (operand[3:0] == 4'hF);
		return f;
	endfunction

	// A new instruction may enter whenever the result register is free or drains now.
	assign instr.ready = !res_valid_q || result.ready;
	assign accept      = instr.valid && instr.ready;

	assign imm16     = {instr.third_byte, instr.second_byte};
	assign jr_offset = {{BYTE_W{instr.second_byte[BYTE_W-1]}}, instr.second_byte};

	always_comb begin
		acc_n     = acc_q;
		flags_n   = flags_q;
		bc_n      = bc_q;
		hl_n      = hl_q;
		sp_n      = sp_q;
		stopped_n = stopped_q;
		pc_base   = pc_q;
		len_n     = 2'd0;
		ticks_n   = '0;
		wr_n      = 1'b0;
		waddr_n   = '0;
		if (!stopped_q) begin
			case (instr.opcode_byte)
				OP_LD_BC_D16: begin
					bc_n = imm16; len_n = 2'd3; ticks_n = 5'd12;
				end
				OP_LD_IBC_A: begin
					wr_n = 1'b1; waddr_n = bc_q; len_n = 2'd1; ticks_n = 5'd8;
				end
				OP_INC_BC: begin
					bc_n = bc_q + 16'd1; len_n = 2'd1; ticks_n = 5'd8;
				end
				OP_INC_B: begin
					flags_n = inc_flags(bc_q[15:8], flags_q);
					bc_n = {bc_q[15:8] + 8'd1, bc_q[7:0]};
					len_n = 2'd1; ticks_n = 5'd4;
				end
				OP_INC_C: begin
					flags_n = inc_flags(bc_q[7:0], flags_q);
					bc_n = {bc_q[15:8], bc_q[7:0] + 8'd1};
					len_n = 2'd1; ticks_n = 5'd4;
				end
				OP_LD_C_D8: begin
					bc_n = {bc_q[15:8], instr.second_byte}; len_n = 2'd2; ticks_n = 5'd8;
				end
				OP_JR_NZ: begin
					len_n = 2'd2;
					if (!flags_q[FLAG_Z]) begin
						// The offset is relative to the byte after the instruction.
						pc_base = pc_q + jr_offset;
						ticks_n = 5'd12;
					end else begin
						ticks_n = 5'd8;
					end
				end
				OP_LD_HL_D16: begin
					hl_n = imm16; len_n = 2'd3; ticks_n = 5'd12;
				end
				OP_LD_SP_D16: begin
					sp_n = imm16; len_n = 2'd3; ticks_n = 5'd12;
				end
				OP_LDD_IHL_A: begin
					// The write uses HL ahead of the decrement.
					wr_n = 1'b1; waddr_n = hl_q; hl_n = hl_q - 16'd1;
					len_n = 2'd1; ticks_n = 5'd8;
				end
				OP_LD_A_D8: begin
					acc_n = instr.second_byte; len_n = 2'd2; ticks_n = 5'd8;
				end
				OP_LD_IHL_A: begin
					wr_n = 1'b1; waddr_n = hl_q; len_n = 2'd1; ticks_n = 5'd8;
				end
				OP_XOR_A: begin
					acc_n = '0; flags_n = '0; flags_n[FLAG_Z] = 1'b1;
					len_n = 2'd1; ticks_n = 5'd4;
				end
				OP_LDH_IA8_A: begin
					wr_n = 1'b1; waddr_n = {HIGH_PAGE, instr.second_byte};
					len_n = 2'd2; ticks_n = 5'd12;
				end
				OP_LDH_IC_A: begin
					wr_n = 1'b1; waddr_n = {HIGH_PAGE, bc_q[7:0]};
					len_n = 2'd1; ticks_n = 5'd8;
				end
				OP_PREFIX_CB: begin
					if (instr.second_byte == CB_BIT7_H) begin
						flags_n = '0;
						flags_n[FLAG_C] = flags_q[FLAG_C];
						flags_n[FLAG_H] = 1'b1;
						flags_n[FLAG_Z] = !hl_q[15];
						len_n = 2'd2; ticks_n = 5'd8;
					end else begin
						stopped_n = 1'b1;
					end
				end
				default: begin
					stopped_n = 1'b1;
				end
			endcase
		end
		if (stopped_n) begin
			// A stopping opcode changes nothing and reports no work.
			wr_n    = 1'b0;
			waddr_n = '0;
			ticks_n = '0;
			pc_n    = pc_q;
		end else begin
			pc_n = pc_base + {{(WORD_W-2){1'b0}}, len_n};
		end
	end

	// Register file; it moves only when an instruction is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			flags_q   <= '0;
			bc_q      <= '0;
			hl_q      <= '0;
			sp_q      <= '0;
			pc_q      <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			acc_q     <= acc_n;
			flags_q   <= flags_n;
			bc_q      <= bc_n;
			hl_q      <= hl_n;
			sp_q      <= sp_n;
			pc_q      <= pc_n;
			stopped_q <= stopped_n;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded with the state after the instruction.
	always_ff @(posedge clk) begin
		if (accept) begin
			result.next_pc        <= pc_n;
			result.mem_write      <= wr_n;
			result.write_addr     <= waddr_n;
			result.write_data     <= wr_n ? acc_q : '0;
			result.halted         <= stopped_n;
			result.machine_cycles <= ticks_n[TICK_W-1:2];
			result.clock_cycles   <= ticks_n;
			result.acc_out        <= acc_n;
			result.flags_out      <= flags_n;
			result.bc_out         <= bc_n;
			result.hl_out         <= hl_n;
			result.sp_out         <= sp_n;
		end
	end

	assign result.valid = res_valid_q;

`ifndef SYNTHESIS
	// Once stopped, the CPU stays stopped until reset.
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stopped CPU resumed without reset");

	// A halted result reports no work and no write.
	a_halt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.halted) |->
		(result.clock_cycles == '0 && !result.mem_write))
		else $error("halted result carries work");

	// Machine cycles are the clock ticks divided by four.
	a_cycle_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.clock_cycles == {result.machine_cycles, 2'b00}))
		else $error("machine cycles do not match clock ticks");

	// An empty result register never blocks the input.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> instr.ready)
		else $error("input stalled with an empty result register");
`endif

endmodule
